/* design/lass_pkg.sv */
// ----------------------------------------------------------------------------
// LED attack/sustain sequencer package
// Shared types, item kind codes and sequence slot codes.
// ----------------------------------------------------------------------------
package lass_pkg;

    // Default depth of one stored sequence
    localparam int MAX_EVENTS_DEF = 16;

    // Width of an event count field
    localparam int CNT_W = 5;

    typedef logic [2:0]       kind_t;
    typedef logic [7:0]       level_t;
    typedef logic [15:0]      frames_t;
    typedef logic [CNT_W-1:0] count_t;
    typedef logic [3:0]       index_t;
    typedef logic [1:0]       slot_t;

    // One colour event as held in the slot and active stores
    typedef struct packed {
        level_t  red;
        level_t  green;
        level_t  blue;
        frames_t length;
    } entry_t;

    // Item kinds
    localparam kind_t KIND_TICK    = 3'd0;
    localparam kind_t KIND_TRIGGER = 3'd1;
    localparam kind_t KIND_EVENT   = 3'd2;
    localparam kind_t KIND_HEADER  = 3'd3;
    localparam kind_t KIND_GAMMA   = 3'd4;

    // Edge and phase codes; a slot is {edge, phase}
    localparam logic EDGE_FALL     = 1'b0;
    localparam logic EDGE_RISE     = 1'b1;
    localparam logic PHASE_ATTACK  = 1'b0;
    localparam logic PHASE_SUSTAIN = 1'b1;

    // Fall sustain doubles as the blank off sequence
    localparam slot_t SLOT_BLANK = {EDGE_FALL, PHASE_SUSTAIN};

endpackage

/* design/lass_if.sv */
// ----------------------------------------------------------------------------
// LED attack/sustain sequencer channel interfaces
// Valid/ready channels for items, results and the gamma enable register.
// ----------------------------------------------------------------------------
interface lass_item_if;
    import lass_pkg::*;

    logic    valid;
    logic    ready;
    kind_t   kind;
    logic    edge_req;
    logic    phase;
    index_t  event_index;
    level_t  red;
    level_t  green;
    level_t  blue;
    frames_t frame_count;
    count_t  event_count;
    logic    loop_flag;
    level_t  gamma_index;
    level_t  gamma_value;

    modport source (
        output valid, kind, edge_req, phase, event_index, red, green, blue,
               frame_count, event_count, loop_flag, gamma_index, gamma_value,
        input  ready
    );

    modport sink (
        input  valid, kind, edge_req, phase, event_index, red, green, blue,
               frame_count, event_count, loop_flag, gamma_index, gamma_value,
        output ready
    );
endinterface

interface lass_res_if;
    import lass_pkg::*;

    logic    valid;
    logic    ready;
    level_t  out_red;
    level_t  out_green;
    level_t  out_blue;
    logic    current_edge;
    logic    current_phase;
    index_t  event_position;
    frames_t frames_remaining;
    logic    is_blank;

    modport source (
        output valid, out_red, out_green, out_blue, current_edge, current_phase,
               event_position, frames_remaining, is_blank,
        input  ready
    );

    modport sink (
        input  valid, out_red, out_green, out_blue, current_edge, current_phase,
               event_position, frames_remaining, is_blank,
        output ready
    );
endinterface

interface lass_cfg_if;
    logic valid;
    logic ready;
    logic gamma_enable;

    modport source (
        output valid, gamma_enable,
        input  ready
    );

    modport sink (
        input  valid, gamma_enable,
        output ready
    );
endinterface

/* design/lass_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lass_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* design/lass_seq.sv */
// ----------------------------------------------------------------------------
// LED attack/sustain sequencer control
// Item decode, play state, sequence copy and gamma lookup sequencer.
// ----------------------------------------------------------------------------
module lass_seq #(
    parameter int MAX_EVENTS = lass_pkg::MAX_EVENTS_DEF,
    localparam int EV_W      = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    lass_item_if.sink            item,
    lass_res_if.source           result,
    lass_cfg_if.sink             cfg,
    // slot store
    output logic                 slot_we,
    output logic [EV_W+1:0]      slot_waddr,
    output lass_pkg::entry_t     slot_wdata,
    output logic [EV_W+1:0]      slot_raddr,
    input  lass_pkg::entry_t     slot_rdata,
    // active store
    output logic                 act_we,
    output logic [EV_W-1:0]      act_waddr,
    output lass_pkg::entry_t     act_wdata,
    output logic [EV_W-1:0]      act_raddr,
    input  lass_pkg::entry_t     act_rdata,
    // gamma table
    output logic                 gamma_we,
    output lass_pkg::level_t     gamma_waddr,
    output lass_pkg::level_t     gamma_wdata,
    output lass_pkg::level_t     gamma_raddr,
    input  lass_pkg::level_t     gamma_rdata
);

    import lass_pkg::*;

    localparam int CP_W  = EV_W + 1;
    localparam int CMP_W = (CP_W > CNT_W) ? CP_W : CNT_W;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_COPY   = 3'd1;
    localparam logic [2:0] ST_READ   = 3'd2;
    localparam logic [2:0] ST_COLOUR = 3'd3;
    localparam logic [2:0] ST_GAMMA  = 3'd4;
    localparam logic [2:0] ST_OUT    = 3'd5;

    localparam logic [1:0] LANE_RED   = 2'd0;
    localparam logic [1:0] LANE_GREEN = 2'd1;
    localparam logic [1:0] LANE_BLUE  = 2'd2;
    localparam logic [1:0] LANE_DONE  = 2'd3;

    // Frames left after the first frame of an event; zero counts as one
    function automatic frames_t first_frames(input frames_t len);
        first_frames = (len == '0) ? '0 : len - frames_t'(1);
    endfunction

    logic [2:0]      state_reg, state_next;
    logic [CP_W-1:0] copy_cnt_reg, copy_cnt_next;
    logic [1:0]      lane_reg, lane_next;
    slot_t           slot_sel_reg, slot_sel_next;
    logic            reload_reg, reload_next;

    count_t          slot_cnt_reg [4];
    count_t          slot_cnt_next [4];
    logic [3:0]      slot_loop_reg, slot_loop_next;
    logic            slot_zero_reg, slot_zero_next;

    logic            act_zero_reg, act_zero_next;
    count_t          act_cnt_reg, act_cnt_next;
    logic            act_loop_reg, act_loop_next;
    logic            play_edge_reg, play_edge_next;
    logic            play_phase_reg, play_phase_next;
    logic [EV_W-1:0] ptr_reg, ptr_next;
    frames_t         frame_reg, frame_next;
    logic            pend_valid_reg, pend_valid_next;
    logic            pend_edge_reg, pend_edge_next;
    logic            blank_reg, blank_next;
    logic            gamma_en_reg, gamma_en_next;

    entry_t          raw_reg, raw_next;
    level_t          red_reg, red_next;
    level_t          green_reg, green_next;
    level_t          blue_reg, blue_next;

    logic            item_fire;
    slot_t           item_slot;
    logic            idx_ok;
    count_t          hdr_count;
    logic [CP_W-1:0] ptr_inc;
    logic            wrap;
    logic            copy_last;
    entry_t          copy_entry;
    entry_t          act_entry;
    logic            start_now;
    slot_t           start_slot;
    logic            blank_now;

    // Handshakes
    assign item.ready   = (state_reg == ST_IDLE);
    assign item_fire    = item.valid && item.ready;
    assign cfg.ready    = 1'b1;
    assign result.valid = (state_reg == ST_OUT);

    // Item decode
    assign item_slot = {item.edge_req, item.phase};
    assign idx_ok    = (CMP_W'(item.event_index) < CMP_W'(MAX_EVENTS));
    assign hdr_count = (CMP_W'(item.event_count) > CMP_W'(MAX_EVENTS)) ?
                       count_t'(MAX_EVENTS) : item.event_count;

    // Event step compare
    assign ptr_inc = CP_W'(ptr_reg) + CP_W'(1);
    assign wrap    = (CMP_W'(ptr_inc) >= CMP_W'(act_cnt_reg)) ||
                     (ptr_inc >= CP_W'(MAX_EVENTS));

    // Copy pipeline: each entry is written to the active store in the cycle after its slot read
    assign copy_last  = (copy_cnt_reg == CP_W'(MAX_EVENTS));
    assign copy_entry = ((copy_cnt_reg == CP_W'(1)) && (slot_sel_reg == SLOT_BLANK) &&
                         slot_zero_reg) ? '0 : slot_rdata;
    assign act_entry  = ((ptr_reg == '0) && act_zero_reg) ? '0 : act_rdata;

    // Store addressing
    assign slot_waddr  = {item_slot, EV_W'(item.event_index)};
    assign slot_wdata  = '{red: item.red, green: item.green, blue: item.blue,
                           length: item.frame_count};
    assign slot_raddr  = {slot_sel_reg, EV_W'(copy_cnt_reg)};
    assign act_waddr   = EV_W'(copy_cnt_reg - CP_W'(1));
    assign act_wdata   = copy_entry;
    assign act_raddr   = ptr_reg;
    assign gamma_waddr = item.gamma_index;
    assign gamma_wdata = item.gamma_value;

    // Gamma lookup address, one colour component a cycle
    always_comb
    begin
        unique case (lane_reg)
            LANE_RED:   gamma_raddr = raw_reg.red;
            LANE_GREEN: gamma_raddr = raw_reg.green;
            default:    gamma_raddr = raw_reg.blue;
        endcase
    end

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        copy_cnt_next   = copy_cnt_reg;
        lane_next       = lane_reg;
        slot_sel_next   = slot_sel_reg;
        reload_next     = reload_reg;
        slot_cnt_next   = slot_cnt_reg;
        slot_loop_next  = slot_loop_reg;
        slot_zero_next  = slot_zero_reg;
        act_zero_next   = act_zero_reg;
        act_cnt_next    = act_cnt_reg;
        act_loop_next   = act_loop_reg;
        play_edge_next  = play_edge_reg;
        play_phase_next = play_phase_reg;
        ptr_next        = ptr_reg;
        frame_next      = frame_reg;
        pend_valid_next = pend_valid_reg;
        pend_edge_next  = pend_edge_reg;
        blank_next      = blank_reg;
        raw_next        = raw_reg;
        red_next        = red_reg;
        green_next      = green_reg;
        blue_next       = blue_reg;
        slot_we         = 1'b0;
        act_we          = 1'b0;
        gamma_we        = 1'b0;
        start_now       = 1'b0;
        start_slot      = slot_sel_reg;
        blank_now       = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_fire)
                begin
                    state_next  = ST_READ;
                    reload_next = 1'b0;
                    unique case (item.kind)
                        KIND_TICK:
                        begin
                            if (pend_valid_reg)
                            begin
                                // start the latched edge's attack sequence
                                start_now      = 1'b1;
                                start_slot     = {pend_edge_reg, PHASE_ATTACK};
                                play_edge_next = pend_edge_reg;
                            end
                            else if (frame_reg == '0)
                            begin
                                if (act_cnt_reg == '0)
                                begin
                                    blank_now = 1'b1;
                                end
                                else if (wrap)
                                begin
                                    if (act_loop_reg)
                                    begin
                                        ptr_next    = '0;
                                        reload_next = 1'b1;
                                    end
                                    else
                                    begin
                                        // fall through to sustain
                                        start_now  = 1'b1;
                                        start_slot = {play_edge_reg, PHASE_SUSTAIN};
                                    end
                                end
                                else
                                begin
                                    ptr_next    = EV_W'(ptr_inc);
                                    reload_next = 1'b1;
                                end
                            end
                            else
                            begin
                                frame_next = frame_reg - frames_t'(1);
                            end
                        end
                        KIND_TRIGGER:
                        begin
                            pend_valid_next = 1'b1;
                            pend_edge_next  = item.edge_req;
                        end
                        KIND_EVENT:
                        begin
                            if (idx_ok)
                            begin
                                slot_we = 1'b1;
                                if ((item_slot == SLOT_BLANK) && (item.event_index == '0))
                                begin
                                    slot_zero_next = 1'b0;
                                end
                            end
                        end
                        KIND_HEADER:
                        begin
                            slot_cnt_next[item_slot]  = hdr_count;
                            slot_loop_next[item_slot] = item.loop_flag;
                        end
                        KIND_GAMMA:
                        begin
                            gamma_we = 1'b1;
                        end
                        default:
                        begin
                            state_next = ST_READ;
                        end
                    endcase
                end
            end
            ST_COPY:
            begin
                if (copy_cnt_reg != '0)
                begin
                    act_we = 1'b1;
                end
                if (copy_last)
                begin
                    state_next      = ST_READ;
                    reload_next     = 1'b1;
                    ptr_next        = '0;
                    act_cnt_next    = slot_cnt_reg[slot_sel_reg];
                    act_loop_next   = slot_loop_reg[slot_sel_reg];
                    play_edge_next  = slot_sel_reg[1];
                    play_phase_next = slot_sel_reg[0];
                    blank_next      = 1'b0;
                    act_zero_next   = 1'b0;
                end
                else
                begin
                    copy_cnt_next = copy_cnt_reg + CP_W'(1);
                end
            end
            ST_READ:
            begin
                state_next = ST_COLOUR;
            end
            ST_COLOUR:
            begin
                // pick up the current event and reload the frame count on a step
                if (reload_reg)
                begin
                    frame_next = first_frames(act_entry.length);
                end
                raw_next = act_entry;
                if (gamma_en_reg)
                begin
                    lane_next  = LANE_RED;
                    state_next = ST_GAMMA;
                end
                else
                begin
                    red_next   = act_entry.red;
                    green_next = act_entry.green;
                    blue_next  = act_entry.blue;
                    state_next = ST_OUT;
                end
            end
            ST_GAMMA:
            begin
                lane_next = lane_reg + 2'd1;
                unique case (lane_reg)
                    LANE_RED:
                    begin
                    end
                    LANE_GREEN:
                    begin
                        red_next = gamma_rdata;
                    end
                    LANE_BLUE:
                    begin
                        green_next = gamma_rdata;
                    end
                    LANE_DONE:
                    begin
                        blue_next  = gamma_rdata;
                        state_next = ST_OUT;
                    end
                endcase
            end
            ST_OUT:
            begin
                if (result.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Begin a sequence copy, or blank when the target is empty
        if (start_now)
        begin
            pend_valid_next = 1'b0;
            pend_edge_next  = 1'b0;
            if (slot_cnt_reg[start_slot] == '0)
            begin
                blank_now = 1'b1;
            end
            else
            begin
                slot_sel_next = start_slot;
                copy_cnt_next = '0;
                state_next    = ST_COPY;
            end
        end

        // Blank: fall sustain becomes one black looping event and plays
        if (blank_now)
        begin
            slot_cnt_next[SLOT_BLANK]  = count_t'(1);
            slot_loop_next[SLOT_BLANK] = 1'b1;
            slot_zero_next  = 1'b1;
            pend_valid_next = 1'b0;
            pend_edge_next  = 1'b0;
            play_edge_next  = EDGE_FALL;
            play_phase_next = PHASE_SUSTAIN;
            act_zero_next   = 1'b1;
            act_cnt_next    = count_t'(1);
            act_loop_next   = 1'b1;
            ptr_next        = '0;
            frame_next      = '0;
            blank_next      = 1'b1;
            reload_next     = 1'b0;
            state_next      = ST_READ;
        end
    end

    // Gamma enable register
    assign gamma_en_next = cfg.valid ? cfg.gamma_enable : gamma_en_reg;

    // Control and play state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            copy_cnt_reg   <= '0;
            lane_reg       <= LANE_RED;
            slot_sel_reg   <= SLOT_BLANK;
            reload_reg     <= 1'b0;
            for (int i = 0; i < 4; i++)
            begin
                slot_cnt_reg[i]  <= (slot_t'(i) == SLOT_BLANK) ? count_t'(1) : '0;
                slot_loop_reg[i] <= (slot_t'(i) == SLOT_BLANK);
            end
            slot_zero_reg  <= 1'b1;
            act_zero_reg   <= 1'b1;
            act_cnt_reg    <= count_t'(1);
            act_loop_reg   <= 1'b1;
            play_edge_reg  <= EDGE_FALL;
            play_phase_reg <= PHASE_SUSTAIN;
            ptr_reg        <= '0;
            frame_reg      <= '0;
            pend_valid_reg <= 1'b0;
            pend_edge_reg  <= 1'b0;
            blank_reg      <= 1'b1;
            gamma_en_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            copy_cnt_reg   <= copy_cnt_next;
            lane_reg       <= lane_next;
            slot_sel_reg   <= slot_sel_next;
            reload_reg     <= reload_next;
            slot_cnt_reg   <= slot_cnt_next;
            slot_loop_reg  <= slot_loop_next;
            slot_zero_reg  <= slot_zero_next;
            act_zero_reg   <= act_zero_next;
            act_cnt_reg    <= act_cnt_next;
            act_loop_reg   <= act_loop_next;
            play_edge_reg  <= play_edge_next;
            play_phase_reg <= play_phase_next;
            ptr_reg        <= ptr_next;
            frame_reg      <= frame_next;
            pend_valid_reg <= pend_valid_next;
            pend_edge_reg  <= pend_edge_next;
            blank_reg      <= blank_next;
            gamma_en_reg   <= gamma_en_next;
        end
    end

    // Colour payload
    always_ff @(posedge clk)
    begin
        raw_reg   <= raw_next;
        red_reg   <= red_next;
        green_reg <= green_next;
        blue_reg  <= blue_next;
    end

    // Result transfer
    assign result.out_red          = red_reg;
    assign result.out_green        = green_reg;
    assign result.out_blue         = blue_reg;
    assign result.current_edge     = play_edge_reg;
    assign result.current_phase    = play_phase_reg;
    assign result.event_position   = index_t'(ptr_reg);
    assign result.frames_remaining = frame_reg;
    assign result.is_blank         = blank_reg;

endmodule

/* design/led_attack_sustain_sequencer_top.sv */
// ----------------------------------------------------------------------------
// LED attack/sustain sequencer
// Plays one LED's colour animation from four stored event sequences.
// ----------------------------------------------------------------------------
// Steps: an item transfer passes through ST_READ and ST_COLOUR to ST_OUT; with gamma
//   on, ST_GAMMA comes between (one gamma table read per colour component on a single read port).
// A tick that starts a sequence first passes through ST_COPY: the events are
//   copied one per cycle through the slot store's read port.
// One item at a time: item ready again the cycle after the result transfers.
// Reset (rst_n, asynchronous): blank fall sustain plays, gamma off, no
//   clearing pass; gamma table and unwritten events are undefined.
// ----------------------------------------------------------------------------
module led_attack_sustain_sequencer_top #(
    parameter int MAX_EVENTS = lass_pkg::MAX_EVENTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    lass_item_if.sink   item,
    lass_res_if.source  result,
    lass_cfg_if.sink    cfg
);

    import lass_pkg::*;

    localparam int EV_W = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;

    logic            slot_we;
    logic [EV_W+1:0] slot_waddr;
    entry_t          slot_wdata;
    logic [EV_W+1:0] slot_raddr;
    entry_t          slot_rdata;
    logic            act_we;
    logic [EV_W-1:0] act_waddr;
    entry_t          act_wdata;
    logic [EV_W-1:0] act_raddr;
    entry_t          act_rdata;
    logic            gamma_we;
    level_t          gamma_waddr;
    level_t          gamma_wdata;
    level_t          gamma_raddr;
    level_t          gamma_rdata;

    // Sequencer and play state
    lass_seq #(
        .MAX_EVENTS (MAX_EVENTS)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item),
        .result      (result),
        .cfg         (cfg),
        .slot_we     (slot_we),
        .slot_waddr  (slot_waddr),
        .slot_wdata  (slot_wdata),
        .slot_raddr  (slot_raddr),
        .slot_rdata  (slot_rdata),
        .act_we      (act_we),
        .act_waddr   (act_waddr),
        .act_wdata   (act_wdata),
        .act_raddr   (act_raddr),
        .act_rdata   (act_rdata),
        .gamma_we    (gamma_we),
        .gamma_waddr (gamma_waddr),
        .gamma_wdata (gamma_wdata),
        .gamma_raddr (gamma_raddr),
        .gamma_rdata (gamma_rdata)
    );

    // Four stored sequences, each on a power-of-two boundary
    lass_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (4 << EV_W)
    ) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    // Sequence being played
    lass_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (MAX_EVENTS)
    ) u_act_ram (
        .clk   (clk),
        .we    (act_we),
        .waddr (act_waddr),
        .wdata (act_wdata),
        .raddr (act_raddr),
        .rdata (act_rdata)
    );

    // Gamma table
    lass_ram #(
        .WIDTH ($bits(level_t)),
        .DEPTH (256)
    ) u_gamma_ram (
        .clk   (clk),
        .we    (gamma_we),
        .waddr (gamma_waddr),
        .wdata (gamma_wdata),
        .raddr (gamma_raddr),
        .rdata (gamma_rdata)
    );

endmodule

/* design/lass_checker.sv */
// ----------------------------------------------------------------------------
// LED attack/sustain sequencer checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module lass_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input lass_pkg::level_t  out_red,
    input lass_pkg::level_t  out_green,
    input lass_pkg::level_t  out_blue,
    input logic              current_edge,
    input logic              current_phase,
    input lass_pkg::index_t  event_position,
    input lass_pkg::frames_t frames_remaining,
    input logic              is_blank
);

    import lass_pkg::*;

    // Never take an item while a result is on offer
    a_busy_while_result: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("item ready while a result is pending");

    // Drop ready after each item transfer
    a_busy_after_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("ready held after item transfer");

    // Hold a stalled result
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_red) &&
            $stable(out_green) && $stable(out_blue) && $stable(current_edge) &&
            $stable(current_phase) && $stable(event_position) &&
            $stable(frames_remaining) && $stable(is_blank)))
        else $error("stalled result changed");

    // Blank always plays fall sustain at its first event with no frames left
    a_blank_state: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && is_blank) |-> ((current_edge == EDGE_FALL) &&
            (current_phase == PHASE_SUSTAIN) && (event_position == '0) &&
            (frames_remaining == '0)))
        else $error("blank result with inconsistent play state");

endmodule

bind led_attack_sustain_sequencer_top lass_checker u_lass_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (item.valid),
    .in_ready         (item.ready),
    .out_valid        (result.valid),
    .out_ready        (result.ready),
    .out_red          (result.out_red),
    .out_green        (result.out_green),
    .out_blue         (result.out_blue),
    .current_edge     (result.current_edge),
    .current_phase    (result.current_phase),
    .event_position   (result.event_position),
    .frames_remaining (result.frames_remaining),
    .is_blank         (result.is_blank)
);
